>>> sv/websocket_frame_deframer_top_defines.svh
// Assertion macros for the WebSocket frame deframer checker.
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define WSDF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsdf checker: same-cycle rule violated");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define WSDF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsdf checker: next-cycle rule violated");

`endif

>>> sv/wsdf_pkg.sv
// Package: types and constants of the WebSocket frame deframer.
`timescale 1ns / 1ps
`default_nettype none
package wsdf_pkg;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DONE    = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ST_PROGRESS = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_SHORT    = 2'd2
    } status_t;

    localparam logic [6:0] LEN_EXT16  = 7'd126;
    localparam logic [6:0] LEN_EXT64  = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [2:0] KEY_BYTES   = 3'd4;

    typedef struct packed {
        logic       has_data;
        logic [7:0] data_byte;
        logic       payload_final;
        logic       end_of_buffer;
        logic [1:0] frame_status;
        logic       fin_bit;
        logic [3:0] frame_opcode;
    } res_t;

endpackage
`default_nettype wire

>>> sv/wsdf_in_if.sv
// Input channel interface: raw buffer bytes with buffer-end flag.
`timescale 1ns / 1ps
`default_nettype none
interface wsdf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       buffer_end;

    modport source (output valid, output in_byte, output buffer_end, input ready);
    modport sink   (input valid, input in_byte, input buffer_end, output ready);
endinterface
`default_nettype wire

>>> sv/wsdf_out_if.sv
// Output channel interface: unmasked payload bytes and frame status.
`timescale 1ns / 1ps
`default_nettype none
interface wsdf_out_if;
    logic       valid;
    logic       ready;
    logic       has_data;
    logic [7:0] data_byte;
    logic       payload_final;
    logic       end_of_buffer;
    logic [1:0] frame_status;
    logic       fin_bit;
    logic [3:0] frame_opcode;

    modport source (output valid, output has_data, output data_byte, output payload_final,
                    output end_of_buffer, output frame_status, output fin_bit,
                    output frame_opcode, input ready);
    modport sink   (input valid, input has_data, input data_byte, input payload_final,
                    input end_of_buffer, input frame_status, input fin_bit,
                    input frame_opcode, output ready);
endinterface
`default_nettype wire

>>> sv/websocket_frame_deframer_top.sv
// Top level: WebSocket frame deframer, header parse, unmasking and buffer status.
//
// Takes one buffer byte per cycle on in_chan while in_chan.ready is high and parses the
// first frame of the buffer: header, 16/64-bit extended length, optional 4-byte mask key.
// Each payload byte leaves on out_chan unmasked, from the output register; the byte
// flagged buffer_end gives a closing transaction with status complete or too short, and
// all state then returns to reset for the next buffer. Header, key and trailing bytes give
// no transaction. Sustained rate is one byte per cycle while out_chan does not stall, set
// by the per-byte phase update and the 64-bit remaining-length down counter. A two-entry
// output buffer (output register plus skid register) takes one more transaction-producing
// byte while out_chan stalls; in_chan.ready then stays low until the output register drains.
// Bytes that give no transaction keep flowing while only the output register is full.
`timescale 1ns / 1ps
`default_nettype none
module websocket_frame_deframer_top (
    input  wire        clk,
    input  wire        rst_n,
    wsdf_in_if.sink    in_chan,
    wsdf_out_if.source out_chan
);

    wsdf_pkg::phase_t phase_reg, phase_next;
    logic        masked_reg, masked_next;
    logic [3:0]  len_left_reg, len_left_next;
    logic [63:0] remain_reg, remain_next;
    logic [31:0] key_reg, key_next;
    logic [2:0]  key_left_reg, key_left_next;
    logic [1:0]  idx_reg, idx_next;
    logic        fin_reg, fin_next;
    logic [3:0]  opcode_reg, opcode_next;

    wsdf_pkg::res_t out_reg, skid_reg, res;
    logic        out_valid_reg, skid_valid_reg;
    logic        in_take, out_take, res_fire, is_data, is_final;
    logic [63:0] ext_len;
    logic [7:0]  key_byte, b;

    assign b        = in_chan.in_byte;
    assign in_chan.ready = !skid_valid_reg;
    assign in_take  = in_chan.valid && !skid_valid_reg;
    assign out_take = out_valid_reg && out_chan.ready;
    assign ext_len  = {remain_reg[55:0], b};

    always_comb
    begin
        case (idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        masked_next   = masked_reg;
        len_left_next = len_left_reg;
        remain_next   = remain_reg;
        key_next      = key_reg;
        key_left_next = key_left_reg;
        idx_next      = idx_reg;
        fin_next      = fin_reg;
        opcode_next   = opcode_reg;
        is_data       = 1'b0;
        is_final      = 1'b0;

        unique case (phase_reg)
            wsdf_pkg::PH_HDR0:
            begin
                fin_next    = b[7];
                opcode_next = b[3:0];
                phase_next  = wsdf_pkg::PH_HDR1;
            end
            wsdf_pkg::PH_HDR1:
            begin
                masked_next = b[7];
                remain_next = '0;
                if (b[6:0] == wsdf_pkg::LEN_EXT16)
                begin
                    len_left_next = wsdf_pkg::EXT16_BYTES;
                    phase_next    = wsdf_pkg::PH_EXTLEN;
                end
                else if (b[6:0] == wsdf_pkg::LEN_EXT64)
                begin
                    len_left_next = wsdf_pkg::EXT64_BYTES;
                    phase_next    = wsdf_pkg::PH_EXTLEN;
                end
                else
                begin
                    remain_next = {57'd0, b[6:0]};
                    if (b[7])
                    begin
                        key_left_next = wsdf_pkg::KEY_BYTES;
                        phase_next    = wsdf_pkg::PH_MASK;
                    end
                    else
                        phase_next = (b[6:0] == 7'd0) ? wsdf_pkg::PH_DONE
                                                      : wsdf_pkg::PH_PAYLOAD;
                end
            end
            wsdf_pkg::PH_EXTLEN:
            begin
                remain_next   = ext_len;
                len_left_next = len_left_reg - 4'd1;
                if (len_left_reg == 4'd1)
                begin
                    if (masked_reg)
                    begin
                        key_left_next = wsdf_pkg::KEY_BYTES;
                        phase_next    = wsdf_pkg::PH_MASK;
                    end
                    else
                        phase_next = (ext_len == 64'd0) ? wsdf_pkg::PH_DONE
                                                        : wsdf_pkg::PH_PAYLOAD;
                end
            end
            wsdf_pkg::PH_MASK:
            begin
                key_next      = {key_reg[23:0], b};
                key_left_next = key_left_reg - 3'd1;
                if (key_left_reg == 3'd1)
                    phase_next = (remain_reg == 64'd0) ? wsdf_pkg::PH_DONE
                                                       : wsdf_pkg::PH_PAYLOAD;
            end
            wsdf_pkg::PH_PAYLOAD:
            begin
                is_data     = 1'b1;
                idx_next    = idx_reg + 2'd1;
                remain_next = remain_reg - 64'd1;
                if (remain_reg == 64'd1)
                begin
                    is_final   = 1'b1;
                    phase_next = wsdf_pkg::PH_DONE;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        res.has_data      = is_data;
        res.data_byte     = is_data ? (b ^ (masked_reg ? key_byte : 8'd0)) : 8'd0;
        res.payload_final = is_final;
        res.end_of_buffer = in_chan.buffer_end;
        if (!in_chan.buffer_end)
            res.frame_status = wsdf_pkg::ST_PROGRESS;
        else if (phase_next == wsdf_pkg::PH_DONE)
            res.frame_status = wsdf_pkg::ST_COMPLETE;
        else
            res.frame_status = wsdf_pkg::ST_SHORT;
        res.fin_bit       = fin_next;
        res.frame_opcode  = opcode_next;
    end

    assign res_fire = in_take && (is_data || in_chan.buffer_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= wsdf_pkg::PH_HDR0;
            masked_reg   <= 1'b0;
            len_left_reg <= '0;
            remain_reg   <= '0;
            key_reg      <= '0;
            key_left_reg <= '0;
            idx_reg      <= '0;
            fin_reg      <= 1'b0;
            opcode_reg   <= '0;
        end
        else if (in_take)
        begin
            if (in_chan.buffer_end)
            begin
                phase_reg    <= wsdf_pkg::PH_HDR0;
                masked_reg   <= 1'b0;
                len_left_reg <= '0;
                remain_reg   <= '0;
                key_reg      <= '0;
                key_left_reg <= '0;
                idx_reg      <= '0;
                fin_reg      <= 1'b0;
                opcode_reg   <= '0;
            end
            else
            begin
                phase_reg    <= phase_next;
                masked_reg   <= masked_next;
                len_left_reg <= len_left_next;
                remain_reg   <= remain_next;
                key_reg      <= key_next;
                key_left_reg <= key_left_next;
                idx_reg      <= idx_next;
                fin_reg      <= fin_next;
                opcode_reg   <= opcode_next;
            end
        end
    end

    // output register plus skid register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
                skid_valid_reg <= 1'b0;
        end
        else if (res_fire)
        begin
            if (out_valid_reg && !out_take)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_take)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_reg <= skid_reg;
        end
        else if (res_fire)
        begin
            if (out_valid_reg && !out_take)
                skid_reg <= res;
            else
                out_reg <= res;
        end
    end

    assign out_chan.valid         = out_valid_reg;
    assign out_chan.has_data      = out_reg.has_data;
    assign out_chan.data_byte     = out_reg.data_byte;
    assign out_chan.payload_final = out_reg.payload_final;
    assign out_chan.end_of_buffer = out_reg.end_of_buffer;
    assign out_chan.frame_status  = out_reg.frame_status;
    assign out_chan.fin_bit       = out_reg.fin_bit;
    assign out_chan.frame_opcode  = out_reg.frame_opcode;

endmodule
`default_nettype wire

>>> sv/wsdf_checker.sv
// Checker on the deframer's output port, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "websocket_frame_deframer_top_defines.svh"
module wsdf_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       valid,
    input wire       ready,
    input wire       has_data,
    input wire [7:0] data_byte,
    input wire       payload_final,
    input wire       end_of_buffer,
    input wire [1:0] frame_status
);

    `WSDF_ASSERT_NEXT(a_stall_hold, valid && !ready, valid && $stable(data_byte))
    `WSDF_ASSERT_NOW(a_no_empty, valid && !has_data, end_of_buffer && data_byte == 8'd0)
    `WSDF_ASSERT_NOW(a_status_idle, valid && !end_of_buffer,
        frame_status == wsdf_pkg::ST_PROGRESS)
    `WSDF_ASSERT_NOW(a_status_close, valid && end_of_buffer,
        frame_status == wsdf_pkg::ST_COMPLETE || frame_status == wsdf_pkg::ST_SHORT)
    `WSDF_ASSERT_NOW(a_final_data, valid && payload_final, has_data)

endmodule

bind websocket_frame_deframer_top wsdf_checker u_wsdf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .valid         (out_chan.valid),
    .ready         (out_chan.ready),
    .has_data      (out_chan.has_data),
    .data_byte     (out_chan.data_byte),
    .payload_final (out_chan.payload_final),
    .end_of_buffer (out_chan.end_of_buffer),
    .frame_status  (out_chan.frame_status)
);
`default_nettype wire

>>> tb/tb_websocket_frame_deframer_top.sv
// Testbench: directed and random buffers through the frame deframer, checked by a predictor.
`timescale 1ns / 1ps
module tb_websocket_frame_deframer_top;

    localparam int ITEM_TARGET = 1400;
    localparam int TAIL_START  = ITEM_TARGET - 200;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int NUM_DIRECTED = 27;

    typedef struct packed {
        logic [7:0]     in_byte;
        logic           last;
        logic           typed;
        logic           want;
        wsdf_pkg::res_t want_res;
    } stim_row_t;

    logic clk;
    logic rst_n;

    wsdf_in_if  in_chan ();
    wsdf_out_if out_chan ();

    websocket_frame_deframer_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_chan),
        .out_chan (out_chan)
    );

    wsdf_pkg::res_t expected_results [$];
    int   bytes_sent   = 0;
    int   mismatches   = 0;
    int   quiet_cycles = 0;
    wire  tail_phase   = (bytes_sent >= TAIL_START);

    // predictor state
    wsdf_pkg::phase_t ph    = wsdf_pkg::PH_HDR0;
    logic        masked     = 1'b0;
    logic [3:0]  len_left   = '0;
    logic [63:0] pay_len    = '0;
    logic [63:0] pay_cnt    = '0;
    logic [31:0] key        = '0;
    logic [2:0]  key_left   = '0;
    logic        hdr_fin    = 1'b0;
    logic [3:0]  hdr_opcode = '0;

    stim_row_t directed_rows [0:NUM_DIRECTED-1];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic stim_row_t pr(input logic [7:0] b, input logic last);
        stim_row_t row;
        row = '0;
        row.in_byte = b;
        row.last = last;
        return row;
    endfunction

    function automatic stim_row_t tn(input logic [7:0] b);
        stim_row_t row;
        row = pr(b, 1'b0);
        row.typed = 1'b1;
        return row;
    endfunction

    function automatic stim_row_t tc(input logic [7:0] b, input wsdf_pkg::status_t st,
                                     input logic fin, input logic [3:0] opc);
        stim_row_t row;
        row = pr(b, 1'b1);
        row.typed = 1'b1;
        row.want = 1'b1;
        row.want_res.end_of_buffer = 1'b1;
        row.want_res.frame_status = st;
        row.want_res.fin_bit = fin;
        row.want_res.frame_opcode = opc;
        return row;
    endfunction

    task automatic length_known();
        if (masked)
        begin
            key_left = wsdf_pkg::KEY_BYTES;
            ph = wsdf_pkg::PH_MASK;
        end
        else
        begin
            ph = (pay_len == 0) ? wsdf_pkg::PH_DONE : wsdf_pkg::PH_PAYLOAD;
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b, input logic last, output logic produced,
                                output wsdf_pkg::res_t r);
        logic       data;
        logic       last_payload;
        logic [7:0] val;
        int         key_shift;
        data = 1'b0;
        last_payload = 1'b0;
        val = '0;
        case (ph)
            wsdf_pkg::PH_HDR0:
            begin
                hdr_fin = b[7];
                hdr_opcode = b[3:0];
                ph = wsdf_pkg::PH_HDR1;
            end
            wsdf_pkg::PH_HDR1:
            begin
                masked = b[7];
                pay_len = '0;
                if (b[6:0] == wsdf_pkg::LEN_EXT16)
                begin
                    len_left = wsdf_pkg::EXT16_BYTES;
                    ph = wsdf_pkg::PH_EXTLEN;
                end
                else if (b[6:0] == wsdf_pkg::LEN_EXT64)
                begin
                    len_left = wsdf_pkg::EXT64_BYTES;
                    ph = wsdf_pkg::PH_EXTLEN;
                end
                else
                begin
                    pay_len = {57'd0, b[6:0]};
                    length_known();
                end
            end
            wsdf_pkg::PH_EXTLEN:
            begin
                pay_len = {pay_len[55:0], b};
                len_left = len_left - 4'd1;
                if (len_left == 0)
                    length_known();
            end
            wsdf_pkg::PH_MASK:
            begin
                key = {key[23:0], b};
                key_left = key_left - 3'd1;
                if (key_left == 0)
                    ph = (pay_len == 0) ? wsdf_pkg::PH_DONE : wsdf_pkg::PH_PAYLOAD;
            end
            wsdf_pkg::PH_PAYLOAD:
            begin
                key_shift = 24 - 8 * int'(pay_cnt[1:0]);
                val = masked ? (b ^ key[key_shift +: 8]) : b;
                data = 1'b1;
                pay_cnt = pay_cnt + 64'd1;
                if (pay_cnt == pay_len)
                begin
                    last_payload = 1'b1;
                    ph = wsdf_pkg::PH_DONE;
                end
            end
            default:
            begin
            end
        endcase
        produced = data || last;
        r.has_data = data;
        r.data_byte = val;
        r.payload_final = last_payload;
        r.end_of_buffer = last;
        r.frame_status = !last ? wsdf_pkg::ST_PROGRESS
                               : ((ph == wsdf_pkg::PH_DONE) ? wsdf_pkg::ST_COMPLETE
                                                            : wsdf_pkg::ST_SHORT);
        r.fin_bit = hdr_fin;
        r.frame_opcode = hdr_opcode;
        if (last)
        begin
            ph = wsdf_pkg::PH_HDR0;
            masked = 1'b0;
            len_left = '0;
            pay_len = '0;
            pay_cnt = '0;
            key = '0;
            key_left = '0;
            hdr_fin = 1'b0;
            hdr_opcode = '0;
        end
    endtask

    task automatic send_row(input stim_row_t row, input logic allow_gaps);
        logic produced;
        wsdf_pkg::res_t predicted;
        @(negedge clk);
        if (allow_gaps && !tail_phase && $urandom_range(0, 5) == 0)
        begin
            in_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        in_chan.valid <= 1'b1;
        in_chan.in_byte <= row.in_byte;
        in_chan.buffer_end <= row.last;
        do @(posedge clk); while (!in_chan.ready);
        bytes_sent++;
        deframe_byte(row.in_byte, row.last, produced, predicted);
        if (row.typed)
        begin
            produced = row.want;
            predicted = row.want_res;
        end
        if (produced)
            expected_results = {expected_results, predicted};
    endtask

    task automatic send_random_buffer();
        logic [7:0]  frame_bytes [$];
        logic [63:0] len;
        logic [6:0]  len7;
        logic        masked_hdr;
        logic        calm;
        logic [7:0]  len_hdr;
        int          kind;
        int          body;
        int          cut;
        kind = $urandom_range(0, 9);
        calm = ($urandom_range(0, 3) == 0);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 8)) frame_bytes = {frame_bytes, 8'($urandom)};
        end
        else
        begin
            frame_bytes = {frame_bytes, 8'($urandom)};
            masked_hdr = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                6, 7:
                begin
                    len7 = wsdf_pkg::LEN_EXT16;
                    len = ($urandom_range(0, 5) == 0) ? 64'($urandom_range(0, 65535))
                                                      : 64'($urandom_range(0, 300));
                end
                8, 9:
                begin
                    len7 = wsdf_pkg::LEN_EXT64;
                    len = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                                      : 64'($urandom_range(0, 300));
                end
                default:
                begin
                    len7 = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 125))
                                                       : 7'($urandom_range(0, 20));
                    len = {57'd0, len7};
                end
            endcase
            len_hdr = {masked_hdr, len7};
            frame_bytes = {frame_bytes, len_hdr};
            if (len7 == wsdf_pkg::LEN_EXT16)
            begin
                for (int i = 1; i >= 0; i--)
                    frame_bytes = {frame_bytes, len[8*i +: 8]};
            end
            else if (len7 == wsdf_pkg::LEN_EXT64)
            begin
                for (int i = 7; i >= 0; i--)
                    frame_bytes = {frame_bytes, len[8*i +: 8]};
            end
            if (masked_hdr)
                repeat (4) frame_bytes = {frame_bytes, 8'($urandom)};
            // huge lengths cannot be sent whole; such a buffer always ends short
            body = (len > 64'd400) ? $urandom_range(0, 40) : int'(len);
            repeat (body) frame_bytes = {frame_bytes, 8'($urandom)};
            if (kind <= 2)
            begin
                if (frame_bytes.size() > 1)
                begin
                    cut = $urandom_range(1, frame_bytes.size() - 1);
                    while (frame_bytes.size() > cut)
                        void'(frame_bytes.pop_back());
                end
            end
            else
            begin
                repeat ($urandom_range(0, 3)) frame_bytes = {frame_bytes, 8'($urandom)};
            end
        end
        foreach (frame_bytes[i])
            send_row(pr(frame_bytes[i], i == frame_bytes.size() - 1), !calm);
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    always @(posedge clk)
    begin : out_monitor
        wsdf_pkg::res_t want;
        if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (out_chan.valid && out_chan.ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected transaction data 0x%0h eob %0b",
                                          out_chan.data_byte, out_chan.end_of_buffer));
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("has_data", 8'(out_chan.has_data), 8'(want.has_data));
                check_field("data_byte", out_chan.data_byte, want.data_byte);
                check_field("payload_final", 8'(out_chan.payload_final),
                            8'(want.payload_final));
                check_field("end_of_buffer", 8'(out_chan.end_of_buffer),
                            8'(want.end_of_buffer));
                check_field("frame_status", 8'(out_chan.frame_status), 8'(want.frame_status));
                check_field("fin_bit", 8'(out_chan.fin_bit), 8'(want.fin_bit));
                check_field("frame_opcode", 8'(out_chan.frame_opcode), 8'(want.frame_opcode));
            end
        end
    end

    initial
    begin : sink_pacing
        int stall_left;
        int calm_left;
        stall_left = 0;
        calm_left = 0;
        out_chan.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left != 0)
            begin
                stall_left--;
            end
            else if (calm_left != 0 || tail_phase)
            begin
                if (calm_left != 0)
                    calm_left--;
                out_chan.ready <= 1'b1;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                out_chan.ready <= 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 39) == 0)
                    calm_left = $urandom_range(20, 200);
                out_chan.ready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        directed_rows = '{
            // one-byte buffer
            tc(8'h81, wsdf_pkg::ST_SHORT, 1'b1, 4'h1),
            // empty unmasked frame
            tn(8'h8A), tc(8'h00, wsdf_pkg::ST_COMPLETE, 1'b1, 4'hA),
            // masked two-byte payload, then a trailing byte closes the buffer
            tn(8'h01), tn(8'h82), tn(8'hFF), tn(8'h00), tn(8'hA5), tn(8'h5A),
            pr(8'hFF, 1'b0), pr(8'h00, 1'b0), tc(8'h77, wsdf_pkg::ST_COMPLETE, 1'b0, 4'h1),
            // 16-bit length of one, payload byte is the buffer end
            tn(8'h0F), tn(8'h7E), tn(8'h00), tn(8'h01), pr(8'h00, 1'b1),
            // 64-bit length with top bit set, buffer ends before the key
            tn(8'hF2), tn(8'hFF), tn(8'h80), tn(8'h00), tn(8'h00), tn(8'h00), tn(8'h00),
            tn(8'h00), tn(8'h00), tc(8'h02, wsdf_pkg::ST_SHORT, 1'b1, 4'h2)
        };
        rst_n = 1'b0;
        in_chan.valid = 1'b0;
        in_chan.in_byte = '0;
        in_chan.buffer_end = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_row(directed_rows[i], 1'b1);
        while (bytes_sent < ITEM_TARGET)
            send_random_buffer();
        @(negedge clk);
        in_chan.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
